// ===== rtl/core/apf_pkg.sv =====
// Shared types, constants and helpers for the Art-Net packet filter.
// Used by every module in rtl/core; depends on nothing else.
package apf_pkg;

  localparam int UNIVERSES_DEF = 4;

  // Byte offsets inside the Art-Net payload
  localparam logic [4:0] ID_LEN      = 5'd8;
  localparam logic [4:0] POS_OP_LO   = 5'd8;
  localparam logic [4:0] POS_OP_HI   = 5'd9;
  localparam logic [4:0] POS_SEQ     = 5'd12;
  localparam logic [4:0] POS_SUBUNI  = 5'd14;
  localparam logic [4:0] POS_NET     = 5'd15;
  localparam logic [4:0] POS_LEN_HI  = 5'd16;
  localparam logic [4:0] POS_LEN_LO  = 5'd17;
  localparam logic [4:0] POS_SAT     = 5'd18;
  localparam logic [4:0] BASE_LEN    = 5'd10;
  localparam logic [4:0] DMX_HDR_LEN = 5'd18;

  localparam logic [15:0] OP_POLL    = 16'h2000;
  localparam logic [15:0] OP_DMX     = 16'h5000;
  localparam logic [15:0] OP_ADDRESS = 16'h6000;
  localparam logic [15:0] OP_INPUT   = 16'h7000;

  localparam logic [7:0]  WRAP_HIGH = 8'(8'hFF - 1 - 8'h0F);
  localparam logic [7:0]  WRAP_LOW  = 8'(8'h0F + 1);
  localparam logic [15:0] MAX_DMX   = 16'd512;

  // Configuration register indexes
  localparam logic REG_NODE_NET    = 1'b0;
  localparam logic REG_NODE_SUBNET = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_BAD_ID  = 2'd2,
    ST_BAD_OP  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_POLL    = 2'd1,
    ACT_DELIVER = 2'd2,
    ACT_DROP    = 2'd3
  } action_t;

  typedef struct packed {
    logic [7:0]  packet_byte;
    logic        last_byte;
    logic [31:0] remote_ip;
    logic [15:0] remote_port;
  } apf_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  action;
    logic [3:0]  universe;
    logic [9:0]  dmx_length;
    logic [31:0] reply_ip;
    logic [15:0] reply_port;
  } apf_out_t;

  // Packet summary at the last byte; ACT_DELIVER here means "passed
  // the filters, sequence and length still to check"
  typedef struct packed {
    status_t     status;
    action_t     act;
    logic [3:0]  uni;
    logic [7:0]  seq;
    logic [15:0] len;
    logic [31:0] ip;
    logic [15:0] port;
  } apf_sum_t;

  typedef struct packed {
    logic       en;
    logic [3:0] addr;
    logic [7:0] data;
  } tbl_wr_t;

  function automatic logic [7:0] id_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h41;
      3'd1:    b = 8'h72;
      3'd2:    b = 8'h74;
      3'd3:    b = 8'h2D;
      3'd4:    b = 8'h4E;
      3'd5:    b = 8'h65;
      3'd6:    b = 8'h74;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/apf_parser.sv =====
// Header parser: counts payload bytes, checks the ID and captures header fields.
// Produces the packet summary for the byte being accepted. Depends on apf_pkg.
module apf_parser #(
  parameter int UNIVERSES = apf_pkg::UNIVERSES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  apf_pkg::apf_in_t  in_data,
  input  logic [6:0]        cfg_net,
  input  logic [3:0]        cfg_subnet,
  output apf_pkg::apf_sum_t sum
);
  import apf_pkg::*;

  logic [4:0]  pos_r, pos_nxt;
  logic        id_ok_r, id_ok_nxt;
  logic [7:0]  op_lo_r, op_hi_r, seq_r, subuni_r, net_r, len_hi_r, len_lo_r;
  logic [31:0] ip_r;
  logic [15:0] port_r;

  logic [7:0]  b;
  logic [15:0] op_now, len_now;
  logic [7:0]  seq_now, subuni_now, net_now;
  logic [31:0] ip_now;
  logic [15:0] port_now;
  logic [4:0]  total;
  logic        uni_ok;

  assign b = in_data.packet_byte;

  always_comb begin
    if (pos_r < ID_LEN) begin
      id_ok_nxt = id_ok_r & (b == id_byte(pos_r[2:0]));
    end else begin
      id_ok_nxt = id_ok_r;
    end
    if (in_data.last_byte) begin
      pos_nxt = '0;
    end else if (pos_r < POS_SAT) begin
      pos_nxt = pos_r + 5'd1;
    end else begin
      pos_nxt = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      id_ok_r <= 1'b1;
    end else if (in_accept) begin
      pos_r   <= pos_nxt;
      id_ok_r <= in_data.last_byte ? 1'b1 : id_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (pos_r == '0) begin
        ip_r   <= in_data.remote_ip;
        port_r <= in_data.remote_port;
      end
      if (pos_r == POS_OP_LO)  op_lo_r  <= b;
      if (pos_r == POS_OP_HI)  op_hi_r  <= b;
      if (pos_r == POS_SEQ)    seq_r    <= b;
      if (pos_r == POS_SUBUNI) subuni_r <= b;
      if (pos_r == POS_NET)    net_r    <= b;
      if (pos_r == POS_LEN_HI) len_hi_r <= b;
      if (pos_r == POS_LEN_LO) len_lo_r <= b;
    end
  end

  // Field values including the byte in flight
  always_comb begin
    op_now     = {(pos_r == POS_OP_HI)  ? b : op_hi_r,
                  (pos_r == POS_OP_LO)  ? b : op_lo_r};
    len_now    = {(pos_r == POS_LEN_HI) ? b : len_hi_r,
                  (pos_r == POS_LEN_LO) ? b : len_lo_r};
    seq_now    = (pos_r == POS_SEQ)    ? b : seq_r;
    subuni_now = (pos_r == POS_SUBUNI) ? b : subuni_r;
    net_now    = (pos_r == POS_NET)    ? b : net_r;
    ip_now     = (pos_r == '0) ? in_data.remote_ip   : ip_r;
    port_now   = (pos_r == '0) ? in_data.remote_port : port_r;
    total      = pos_r + 5'd1;
    uni_ok     = {1'b0, subuni_now[3:0]} < 5'(UNIVERSES);
  end

  always_comb begin
    sum        = '0;
    sum.status = ST_OK;
    sum.act    = ACT_NONE;
    sum.uni    = subuni_now[3:0];
    sum.seq    = seq_now;
    sum.len    = len_now;
    priority if (total < BASE_LEN) begin
      sum.status = ST_BAD_LEN;
    end else if (!id_ok_nxt) begin
      sum.status = ST_BAD_ID;
    end else if (op_now == OP_POLL || op_now == OP_ADDRESS || op_now == OP_INPUT) begin
      sum.act  = ACT_POLL;
      sum.ip   = ip_now;
      sum.port = port_now;
    end else if (op_now == OP_DMX) begin
      if (total < DMX_HDR_LEN || net_now != {1'b0, cfg_net} ||
          subuni_now[7:4] != cfg_subnet || !uni_ok) begin
        sum.act = ACT_DROP;
      end else begin
        sum.act = ACT_DELIVER;
      end
    end else begin
      sum.status = ST_BAD_OP;
    end
  end

endmodule

// ===== rtl/core/apf_seq_table.sv =====
// Per-universe last-sequence memory: one read and one write port, registered read.
// Valid bits make unwritten entries read as zero; forwards a same-edge write.
// Depends on apf_pkg.
module apf_seq_table #(
  parameter int UNIVERSES = apf_pkg::UNIVERSES_DEF,
  parameter int AW        = (UNIVERSES > 1) ? $clog2(UNIVERSES) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  input  apf_pkg::tbl_wr_t wr,
  output logic [7:0]      rd_data
);
  import apf_pkg::*;

  logic [7:0]           mem [0:UNIVERSES-1];
  logic [UNIVERSES-1:0] vld_r;
  logic [7:0]           rd_q_r;
  logic                 rd_vld_r;
  logic [AW-1:0]        wr_addr;

  assign wr_addr = wr.addr[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (rd_en) begin
      if (wr.en && wr_addr == rd_addr) begin
        rd_vld_r <= 1'b1;
      end else begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= (wr.en && wr_addr == rd_addr) ? wr.data : mem[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : 8'd0;

endmodule

// ===== rtl/core/apf_verdict.sv =====
// Decision stage: holds the packet summary while the sequence entry is read,
// applies the sequence and length rules, writes back and registers the result.
// Depends on apf_pkg.
module apf_verdict (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  apf_pkg::apf_sum_t sum,
  input  logic [7:0]        rd_data,
  output apf_pkg::tbl_wr_t  tbl_wr,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output apf_pkg::apf_out_t out_data
);
  import apf_pkg::*;

  logic     s1_vld_r;
  apf_sum_t s1_r;
  logic     s1_adv;
  logic     out_vld_r;
  apf_out_t out_r;
  apf_out_t res;
  logic     seq_wr, drop;

  assign s1_adv = s1_vld_r && (!out_vld_r || !out_stall);
  // Hold the input while a finished word cannot move on
  assign busy   = s1_vld_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (load) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_r <= sum;
    end
  end

  always_comb begin
    seq_wr = 1'b0;
    drop   = 1'b0;
    if (s1_r.seq != 8'd0) begin
      if (s1_r.seq <= WRAP_LOW && rd_data >= WRAP_HIGH) begin
        seq_wr = 1'b1;
      end else if (rd_data > s1_r.seq) begin
        drop = 1'b1;
      end else begin
        seq_wr = 1'b1;
      end
    end
    if (s1_r.len > MAX_DMX) begin
      drop = 1'b1;
    end

    res            = '0;
    res.status     = s1_r.status;
    res.action     = s1_r.act;
    res.reply_ip   = s1_r.ip;
    res.reply_port = s1_r.port;
    if (s1_r.act == ACT_DELIVER) begin
      if (drop) begin
        res.action = ACT_DROP;
      end else begin
        res.universe   = s1_r.uni;
        res.dmx_length = s1_r.len[9:0];
      end
    end
  end

  always_comb begin
    tbl_wr.en   = s1_adv && (s1_r.act == ACT_DELIVER) && seq_wr;
    tbl_wr.addr = s1_r.uni;
    tbl_wr.data = s1_r.seq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/artnet_packet_filter_unit.sv =====
// Art-Net packet filter: one payload byte per cycle, one result word per packet.
// The last byte loads the decision stage, which then registers the result word.
// Throughput: 1 byte per cycle; the input stalls only while the decision stage
// holds a word behind a stalled output register.
// Reset (synchronous, rst_n low): byte count and ID flag restart, node registers
// clear, sequence table entries read as zero through per-entry valid bits.
module artnet_packet_filter_unit #(
  parameter int UNIVERSES = apf_pkg::UNIVERSES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  apf_pkg::apf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output apf_pkg::apf_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [6:0]        cfg_wdata
);
  import apf_pkg::*;

  localparam int AW = (UNIVERSES > 1) ? $clog2(UNIVERSES) : 1;

  logic [6:0] node_net_r;
  logic [3:0] node_subnet_r;
  logic       in_accept, busy, load;
  apf_sum_t   sum;
  tbl_wr_t    tbl_wr;
  logic [7:0] rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_net_r    <= '0;
      node_subnet_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NODE_NET:    node_net_r    <= cfg_wdata;
        REG_NODE_SUBNET: node_subnet_r <= cfg_wdata[3:0];
        default:         node_net_r    <= node_net_r;
      endcase
    end
  end

  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;
  assign load      = in_accept && in_data.last_byte;

  apf_parser #(.UNIVERSES(UNIVERSES)) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .in_data    (in_data),
    .cfg_net    (node_net_r),
    .cfg_subnet (node_subnet_r),
    .sum        (sum)
  );

  apf_seq_table #(.UNIVERSES(UNIVERSES), .AW(AW)) u_seq_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (load),
    .rd_addr (sum.uni[AW-1:0]),
    .wr      (tbl_wr),
    .rd_data (rd_data)
  );

  apf_verdict u_verdict (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .sum       (sum),
    .rd_data   (rd_data),
    .tbl_wr    (tbl_wr),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_deliver_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action == ACT_DELIVER |->
      out_data.status == ST_OK && out_data.dmx_length <= 10'd512)
    else $error("delivered DMX with bad status or length");

  a_reply_only_poll: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action != ACT_POLL |->
      out_data.reply_ip == '0 && out_data.reply_port == '0)
    else $error("reply address on a non-poll result");

  a_write_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_wr.en |=> out_valid &&
      (out_data.action == ACT_DELIVER || out_data.action == ACT_DROP))
    else $error("sequence write without a DMX result");

  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(load) || $past(in_stall))
    else $error("input stalled with no packet in the decision stage");
`endif

endmodule
